/* hw/rtl/tmf_pkg.sv */
// Shared constants for the trimmed mean filter.
package tmf_pkg;

  // Fixed field widths of the ports.
  localparam int unsigned SampleW = 12;
  localparam int unsigned MeanW   = 12;

  // Defaults for the top-level parameters.
  localparam int unsigned MaxSamplesDef = 32;
  localparam int unsigned SampleBitsDef = 12;

  // Trim rule: trim = n / TrimDiv when n > TrimDiv, dropped at both ends.
  localparam int unsigned TrimDiv   = 5;
  localparam int unsigned TrimSides = 2;

  // n / 5 == (n * 205) >> 10 for every n below 1024.
  localparam int unsigned RecipMul   = 205;
  localparam int unsigned RecipShift = 10;

endpackage

/* hw/rtl/trimmed_mean_filter.sv */
// Trimmed mean filter: sorted sample memory, trim, sum and serial divide.
//
//  channel  | signals                          | dir | word
//  ---------+----------------------------------+-----+----------------------------
//  in       | in_valid_i in_ready_o            | in  | sample_i[11:0], last_i
//  out      | out_valid_o out_ready_i          | out | mean_o[11:0], overflowed_o
//
// One input word at a time. Insertion walks down the sorted memory one entry
// per cycle. A word with last set is followed by a setup step, a sum of the
// kept entries, a serial divide and the load of the output register. The
// memory needs no clearing: reads only reach entries written in the current
// burst. Reset clears the count, the overflow flag and the control state. The
// output register lets the next word in while a result waits; a second result
// waits until the first is taken.
module trimmed_mean_filter
  import tmf_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = MaxSamplesDef,
  parameter int unsigned SAMPLE_BITS = SampleBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [SampleW-1:0] sample_i,
  input  logic               last_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [MeanW-1:0]   mean_o,
  output logic               overflowed_o
);

  // Count holds 0..MAX_SAMPLES; the address covers the memory depth.
  localparam int unsigned CntW    = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned AddrW   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  // Sum of MAX_SAMPLES full-scale samples never wraps.
  localparam int unsigned SumW    = SAMPLE_BITS + CntW;
  localparam int unsigned BitCntW = $clog2(SumW + 1);
  localparam int unsigned MulW    = CntW + RecipShift;
  localparam int unsigned SExtW   = SampleW + SAMPLE_BITS;
  localparam int unsigned MExtW   = MeanW + SumW;

  typedef enum logic [2:0] {
    StIdle,
    StInsert,
    StSetup,
    StSum,
    StDiv,
    StEmit
  } state_e;

  state_e state_q, state_d;

  // Burst state.
  logic [CntW-1:0]        count_q, count_d;
  logic                   ovf_q, ovf_d;
  logic                   last_q, last_d;
  logic [SAMPLE_BITS-1:0] v_q, v_d;
  logic [CntW-1:0]        pos_q, pos_d;

  // Sum and divide.
  logic [CntW-1:0]        idx_q, idx_d;
  logic [CntW-1:0]        end_q, end_d;
  logic [CntW-1:0]        kept_q, kept_d;
  logic                   rdv_q, rdv_d;
  logic [SumW-1:0]        acc_q, acc_d;
  logic [SumW-1:0]        quo_q, quo_d;
  logic [CntW:0]          rem_q, rem_d;
  logic [BitCntW-1:0]     bit_cnt_q, bit_cnt_d;

  // Output register.
  logic                   out_valid_q, out_valid_d;
  logic [MeanW-1:0]       mean_q, mean_d;
  logic                   ovfl_out_q, ovfl_out_d;

  // Sorted sample memory, one write and one registered read per cycle.
  logic [SAMPLE_BITS-1:0] mem_q [MAX_SAMPLES];
  logic [SAMPLE_BITS-1:0] rdata_q;
  logic                   mem_we;
  logic [AddrW-1:0]       mem_waddr;
  logic [SAMPLE_BITS-1:0] mem_wdata;
  logic [AddrW-1:0]       mem_raddr;

  // Datapath helpers.
  logic [SExtW-1:0]       sample_ext;
  logic [SAMPLE_BITS-1:0] sample_m;
  logic [CntW-1:0]        cnt_m1;
  logic [CntW-1:0]        pos_m1;
  logic [CntW-1:0]        pos_m2;
  logic [MulW-1:0]        trim_prod;
  logic [CntW-1:0]        trim;
  logic [CntW:0]          div_shift;
  logic                   div_bit;
  logic [MExtW-1:0]       quo_ext;

  // Bits above SAMPLE_BITS are ignored; narrower ports are zero-extended.
  assign sample_ext = SExtW'(sample_i);
  assign sample_m   = sample_ext[SAMPLE_BITS-1:0];

  assign cnt_m1 = count_q - CntW'(1);
  assign pos_m1 = pos_q - CntW'(1);
  assign pos_m2 = pos_q - CntW'(2);

  // Trim by reciprocal multiply, zero for short bursts.
  assign trim_prod = MulW'(count_q) * MulW'(RecipMul);
  assign trim = (count_q > CntW'(TrimDiv)) ? trim_prod[MulW-1:RecipShift] : '0;

  // Restoring divide step: one quotient bit per cycle, MSB first.
  assign div_shift = {rem_q[CntW-1:0], quo_q[SumW-1]};
  assign div_bit   = (div_shift >= {1'b0, kept_q});

  assign quo_ext = MExtW'(quo_q);

  assign in_ready_o   = (state_q == StIdle);
  assign out_valid_o  = out_valid_q;
  assign mean_o       = mean_q;
  assign overflowed_o = ovfl_out_q;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    last_d      = last_q;
    v_d         = v_q;
    pos_d       = pos_q;
    idx_d       = idx_q;
    end_d       = end_q;
    kept_d      = kept_q;
    rdv_d       = rdv_q;
    acc_d       = acc_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    bit_cnt_d   = bit_cnt_q;
    out_valid_d = out_valid_q;
    mean_d      = mean_q;
    ovfl_out_d  = ovfl_out_q;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = v_q;
    mem_raddr   = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          last_d = last_i;
          v_d    = sample_m;
          if (count_q < CntW'(MAX_SAMPLES)) begin
            count_d = count_q + CntW'(1);
            pos_d   = count_q;
            if (count_q == '0) begin
              // Empty store: the word lands at the bottom directly.
              mem_we    = 1'b1;
              mem_waddr = '0;
              mem_wdata = sample_m;
              state_d   = last_i ? StSetup : StIdle;
            end else begin
              mem_raddr = cnt_m1[AddrW-1:0];
              state_d   = StInsert;
            end
          end else begin
            // Store full: drop the word, remember the drop in the overflow flag.
            ovf_d   = 1'b1;
            state_d = last_i ? StSetup : StIdle;
          end
        end
      end

      StInsert: begin
        // rdata_q holds entry pos-1; shift it up while it is larger.
        if (pos_q == '0) begin
          mem_we    = 1'b1;
          mem_waddr = '0;
          mem_wdata = v_q;
          state_d   = last_q ? StSetup : StIdle;
        end else if (rdata_q > v_q) begin
          mem_we    = 1'b1;
          mem_waddr = pos_q[AddrW-1:0];
          mem_wdata = rdata_q;
          pos_d     = pos_m1;
          mem_raddr = pos_m2[AddrW-1:0];
        end else begin
          mem_we    = 1'b1;
          mem_waddr = pos_q[AddrW-1:0];
          mem_wdata = v_q;
          state_d   = last_q ? StSetup : StIdle;
        end
      end

      StSetup: begin
        idx_d   = trim;
        end_d   = count_q - trim;
        kept_d  = count_q - CntW'(trim * CntW'(TrimSides));
        acc_d   = '0;
        rdv_d   = 1'b0;
        state_d = StSum;
      end

      StSum: begin
        if (rdv_q) begin
          acc_d = acc_q + SumW'(rdata_q);
        end
        if (idx_q < end_q) begin
          mem_raddr = idx_q[AddrW-1:0];
          idx_d     = idx_q + CntW'(1);
          rdv_d     = 1'b1;
        end else begin
          rdv_d = 1'b0;
          if (!rdv_q) begin
            quo_d     = acc_q;
            rem_d     = '0;
            bit_cnt_d = BitCntW'(SumW);
            state_d   = StDiv;
          end
        end
      end

      StDiv: begin
        if (div_bit) begin
          rem_d = div_shift - {1'b0, kept_q};
        end else begin
          rem_d = div_shift;
        end
        quo_d     = {quo_q[SumW-2:0], div_bit};
        bit_cnt_d = bit_cnt_q - BitCntW'(1);
        if (bit_cnt_q == BitCntW'(1)) begin
          state_d = StEmit;
        end
      end

      StEmit: begin
        if (!out_valid_q || out_ready_i) begin
          mean_d      = quo_ext[MeanW-1:0];
          ovfl_out_d  = ovf_q;
          out_valid_d = 1'b1;
          count_d     = '0;
          ovf_d       = 1'b0;
          state_d     = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      last_q      <= 1'b0;
      v_q         <= '0;
      pos_q       <= '0;
      idx_q       <= '0;
      end_q       <= '0;
      kept_q      <= '0;
      rdv_q       <= 1'b0;
      acc_q       <= '0;
      quo_q       <= '0;
      rem_q       <= '0;
      bit_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      mean_q      <= '0;
      ovfl_out_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      last_q      <= last_d;
      v_q         <= v_d;
      pos_q       <= pos_d;
      idx_q       <= idx_d;
      end_q       <= end_d;
      kept_q      <= kept_d;
      rdv_q       <= rdv_d;
      acc_q       <= acc_d;
      quo_q       <= quo_d;
      rem_q       <= rem_d;
      bit_cnt_q   <= bit_cnt_d;
      out_valid_q <= out_valid_d;
      mean_q      <= mean_d;
      ovfl_out_q  <= ovfl_out_d;
    end
  end

  // Sample memory: write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_raddr];
  end

endmodule
